### hw/rtl/lpht_pkg.sv
package lpht_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT,
        REQ_LOOKUP,
        REQ_REMOVE,
        REQ_CLEAR
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED,
        ST_EXISTING,
        ST_NOT_FOUND,
        ST_REMOVED,
        ST_FULL,
        ST_CLEARED
    } status_t;

endpackage

### hw/rtl/linear_probe_hash_table_core.sv
// Channel  Handshake          Payload
// in       in_valid/in_ready  req_type, key, key_hash, value
// out      out_valid/out_ready status, found, result_value
//
// An insert, lookup or remove probes from its home slot; each slot probed
// takes one read of the slot memory (S_READ) and one compare (S_EVAL).
// A capacity that is not a power of two adds the hash modulo steps S_MOD1, S_MOD2, S_MOD3.
// Clear sweeps the slot memory, emptying one slot a cycle; the same sweep
// empties every slot after reset before the first request is taken.
// A finished result sits in the output register; the next request is taken
// while it waits, and a new result holds until the old one is transferred.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [HASH_W-1:0]   key_hash,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [VALUE_W-1:0]  result_value
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam bit POW2    = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int HALF    = CAPACITY / 2;
    localparam int CNT_W   = $clog2(HALF + 1);
    localparam int MUL_S   = HASH_W + IDX_W;
    localparam int RECIP_W = HASH_W + 1;
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam int REM_W   = IDX_W + 1;
    localparam int RV_W    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [63:0]        RECIP64  = (64'd1 << MUL_S) / CAPACITY;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP64);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_INIT, S_WAIT, S_MOD1, S_MOD2, S_MOD3, S_READ, S_EVAL, S_SWEEP, S_POST
    } step_t;

    typedef enum logic [2:0] {
        A_ACCEPT, A_MUL, A_REM, A_WRAP, A_READ, A_EVAL, A_CLEAR, A_POST
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS, C_IN_XFER, C_IS_CLEAR, C_PROBE_MORE, C_SWEEP_MORE, C_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t go_true;
        step_t go_false;
    } uword_t;

    typedef struct packed {
        logic                  used;
        logic                  tomb;
        logic [HASH_W-1:0]     hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
    } slot_t;

    localparam step_t FIRST_STEP = POW2 ? S_READ : S_MOD1;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            S_INIT:  w = '{A_CLEAR,  C_SWEEP_MORE, S_INIT,     S_WAIT};
            S_WAIT:  w = '{A_ACCEPT, C_IN_XFER,    FIRST_STEP, S_WAIT};
            S_MOD1:  w = '{A_MUL,    C_ALWAYS,     S_MOD2,     S_MOD2};
            S_MOD2:  w = '{A_REM,    C_ALWAYS,     S_MOD3,     S_MOD3};
            S_MOD3:  w = '{A_WRAP,   C_ALWAYS,     S_READ,     S_READ};
            S_READ:  w = '{A_READ,   C_IS_CLEAR,   S_SWEEP,    S_EVAL};
            S_EVAL:  w = '{A_EVAL,   C_PROBE_MORE, S_READ,     S_POST};
            S_SWEEP: w = '{A_CLEAR,  C_SWEEP_MORE, S_SWEEP,    S_POST};
            S_POST:  w = '{A_POST,   C_OUT_FREE,   S_WAIT,     S_POST};
            default: w = '{A_READ,   C_ALWAYS,     S_WAIT,     S_WAIT};
        endcase
        return w;
    endfunction

    slot_t mem [CAPACITY];
    slot_t rd_reg;
    slot_t mem_wdata;
    logic  mem_we;
    logic [IDX_W-1:0] mem_waddr;

    step_t            step_reg;
    step_t            step_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] sweep_reg;
    logic             out_valid_reg;

    req_t                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [IDX_W-1:0]      probe_cnt_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [REM_W-1:0]      rem_reg;
    status_t               res_status_reg;
    logic                  res_found_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    status_t               status_reg;
    logic                  found_reg;
    logic [VALUE_W-1:0]    result_value_reg;

    uword_t            uw;
    logic              in_xfer;
    logic              cond_true;
    logic              rd_hit;
    logic              rd_empty;
    logic              ins_full;
    logic              lap_end;
    logic              do_eval;
    logic              ins_new;
    logic              rem_hit;
    logic              advance;
    logic              post_load;
    logic [HASH_W-1:0] quot;
    req_t              in_op;

    assign uw        = ucode(step_reg);
    assign in_ready  = (step_reg == S_WAIT);
    assign in_xfer   = in_valid && in_ready;
    assign in_op     = req_t'(req_type);

    assign rd_hit    = rd_reg.used && (rd_reg.hash == hash_reg) && (rd_reg.key == key_reg);
    assign rd_empty  = !rd_reg.used && !rd_reg.tomb;
    assign ins_full  = (op_reg == REQ_INSERT) && (count_reg >= CNT_W'(HALF));
    assign lap_end   = (probe_cnt_reg == LAST_IDX);
    assign do_eval   = (uw.act == A_EVAL) && !ins_full;
    assign ins_new   = do_eval && rd_empty && (op_reg == REQ_INSERT);
    assign rem_hit   = do_eval && rd_hit && (op_reg == REQ_REMOVE);
    assign advance   = do_eval && !rd_empty && !rd_hit && !lap_end;
    assign post_load = (uw.act == A_POST) && (!out_valid_reg || out_ready);
    assign quot      = HASH_W'(prod_reg >> MUL_S);

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_IN_XFER:    cond_true = in_xfer;
            C_IS_CLEAR:   cond_true = (op_reg == REQ_CLEAR);
            C_PROBE_MORE: cond_true = advance;
            C_SWEEP_MORE: cond_true = (sweep_reg != LAST_IDX);
            C_OUT_FREE:   cond_true = !out_valid_reg || out_ready;
            default:      cond_true = 1'b0;
        endcase
        step_next = cond_true ? uw.go_true : uw.go_false;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (uw.act == A_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
        end
        else if (ins_new)
        begin
            mem_we    = 1'b1;
            mem_wdata = '{used: 1'b1, tomb: 1'b0, hash: hash_reg, key: key_reg, val: val_reg};
        end
        else if (rem_hit)
        begin
            mem_we    = 1'b1;
            mem_wdata = '{used: 1'b0, tomb: 1'b1, hash: '0, key: key_reg, val: rd_reg.val};
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (uw.act == A_READ)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_INIT;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (uw.act == A_CLEAR)
            begin
                sweep_reg <= (sweep_reg == LAST_IDX) ? '0 : IDX_W'(sweep_reg + 1'b1);
            end
            if (in_xfer && (in_op == REQ_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (ins_new)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            if (post_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg         <= in_op;
            key_reg        <= KEY_BITS'(key);
            hash_reg       <= key_hash;
            val_reg        <= VALUE_BITS'(value);
            addr_reg       <= IDX_W'(key_hash);
            probe_cnt_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
            if (in_op == REQ_CLEAR)
            begin
                res_status_reg <= ST_CLEARED;
            end
            else if (in_op == REQ_INSERT)
            begin
                res_status_reg <= ST_FULL;
            end
            else
            begin
                res_status_reg <= ST_NOT_FOUND;
            end
        end
        if (uw.act == A_MUL)
        begin
            prod_reg <= PROD_W'(hash_reg) * PROD_W'(RECIP);
        end
        if (uw.act == A_REM)
        begin
            rem_reg <= REM_W'(hash_reg - HASH_W'(quot * HASH_W'(CAPACITY)));
        end
        if (uw.act == A_WRAP)
        begin
            addr_reg <= (rem_reg >= REM_W'(CAPACITY)) ?
                        IDX_W'(rem_reg - REM_W'(CAPACITY)) : IDX_W'(rem_reg);
        end
        if (advance)
        begin
            addr_reg      <= (addr_reg == LAST_IDX) ? '0 : IDX_W'(addr_reg + 1'b1);
            probe_cnt_reg <= IDX_W'(probe_cnt_reg + 1'b1);
        end
        if (ins_new)
        begin
            res_status_reg <= ST_INSERTED;
            res_found_reg  <= 1'b1;
            res_value_reg  <= VALUE_W'(val_reg[RV_W-1:0]);
        end
        else if (do_eval && rd_hit)
        begin
            res_status_reg <= (op_reg == REQ_REMOVE) ? ST_REMOVED : ST_EXISTING;
            res_found_reg  <= 1'b1;
            res_value_reg  <= VALUE_W'(rd_reg.val[RV_W-1:0]);
        end
        if (post_load)
        begin
            status_reg       <= res_status_reg;
            found_reg        <= res_found_reg;
            result_value_reg <= res_value_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign result_value = result_value_reg;

endmodule

### tb/linear_probe_hash_table_core_test.sv
`timescale 1ns / 100ps

module linear_probe_hash_table_core_test;
    import lpht_pkg::*;

    localparam int unsigned SLOTS = CAPACITY_DEF;
    localparam int ITEMS = 1650;
    localparam int POOL = 40;
    localparam int FILL = 140;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        req_t              op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VALUE_W-1:0] val;
    } table_req_t;

    typedef struct {
        status_t            status;
        logic               found;
        logic [VALUE_W-1:0] val;
    } table_ans_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [KEY_W-1:0]    key = '0;
    logic [HASH_W-1:0]   key_hash = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  result_value;

    table_req_t requests_waiting[$];
    table_ans_t answers_owed[$];

    bit                 slot_live [SLOTS];
    bit                 slot_tomb [SLOTS];
    logic [HASH_W-1:0]  stored_hash [SLOTS];
    logic [KEY_W-1:0]   stored_key [SLOTS];
    logic [VALUE_W-1:0] stored_val [SLOTS];
    int unsigned        live_count = 0;

    int sent_count = 0;
    int got_count = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    linear_probe_hash_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .key          (key),
        .key_hash     (key_hash),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found        (found),
        .result_value (result_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit table_probe(input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h,
                                       output int unsigned slot, output bit hit);
        int unsigned s;
        slot = 0;
        hit = 1'b0;
        for (int unsigned i = 0; i < SLOTS; i++)
        begin
            s = (h % SLOTS + i) % SLOTS;
            if (slot_tomb[s])
                continue;
            if (!slot_live[s])
            begin
                slot = s;
                return 1'b1;
            end
            if (stored_hash[s] == h && stored_key[s] == k)
            begin
                slot = s;
                hit = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic table_ans_t table_answer(table_req_t r);
        table_ans_t a;
        int unsigned s;
        bit hit;
        bit stopped;
        a.status = ST_NOT_FOUND;
        a.found = 1'b0;
        a.val = '0;
        if (r.op == REQ_CLEAR)
        begin
            for (int unsigned i = 0; i < SLOTS; i++)
            begin
                slot_live[i] = 1'b0;
                slot_tomb[i] = 1'b0;
            end
            live_count = 0;
            a.status = ST_CLEARED;
        end
        else if (r.op == REQ_INSERT)
        begin
            if (live_count >= SLOTS / 2)
                a.status = ST_FULL;
            else
            begin
                stopped = table_probe(r.key, r.hash, s, hit);
                if (!stopped)
                    a.status = ST_FULL;
                else if (hit)
                begin
                    a.status = ST_EXISTING;
                    a.found = 1'b1;
                    a.val = stored_val[s];
                end
                else
                begin
                    slot_live[s] = 1'b1;
                    slot_tomb[s] = 1'b0;
                    stored_hash[s] = r.hash;
                    stored_key[s] = r.key;
                    stored_val[s] = r.val;
                    live_count++;
                    a.status = ST_INSERTED;
                    a.found = 1'b1;
                    a.val = r.val;
                end
            end
        end
        else
        begin
            stopped = table_probe(r.key, r.hash, s, hit);
            if (stopped && hit)
            begin
                a.found = 1'b1;
                a.val = stored_val[s];
                if (r.op == REQ_LOOKUP)
                    a.status = ST_EXISTING;
                else
                begin
                    slot_live[s] = 1'b0;
                    slot_tomb[s] = 1'b1;
                    stored_hash[s] = '0;
                    a.status = ST_REMOVED;
                end
            end
        end
        return a;
    endfunction

    task automatic queue_req(req_t op, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                             logic [VALUE_W-1:0] v);
        table_req_t r;
        r.op = op;
        r.key = k;
        r.hash = h;
        r.val = v;
        requests_waiting.push_back(r);
    endtask

    // hash whose home slot lies within spread slots above base
    function automatic logic [HASH_W-1:0] near_slot(int unsigned base, int unsigned spread);
        logic [HASH_W-1:0] t;
        t = $urandom;
        return t - (t % SLOTS) + (base + $urandom_range(0, spread - 1)) % SLOTS;
    endfunction

    function automatic bit take_break();
        if (sent_count >= 800 && sent_count < 1100)
            return 1'b0;
        return $urandom_range(0, 99) < 33;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        table_req_t cur;
        table_req_t nxt;
        bit busy;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                cur.op = req_t'(req_type);
                cur.key = key;
                cur.hash = key_hash;
                cur.val = value;
                answers_owed.push_back(table_answer(cur));
                sent_count <= sent_count + 1;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (requests_waiting.size() != 0 && !take_break())
                begin
                    nxt = requests_waiting.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.op;
                    key <= nxt.key;
                    key_hash <= nxt.hash;
                    value <= nxt.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        table_ans_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answers_owed.size() == 0)
                begin
                    $display("%0t: unexpected transfer, status %0d value %h",
                             $time, status, result_value);
                    errors++;
                end
                else
                begin
                    want = answers_owed.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        errors++;
                    end
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d got %0d", $time, want.found, found);
                        errors++;
                    end
                    if (result_value !== want.val)
                    begin
                        $display("%0t: result_value expected %h got %h",
                                 $time, want.val, result_value);
                        errors++;
                    end
                end
                got_count <= got_count + 1;
            end
            out_ready <= (hold_left == 0) && !take_break();
        end
    end

    // hold off the output once so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && got_count >= 500)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    initial
    begin
        #(64'd50_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0]  pool_key [POOL];
        logic [HASH_W-1:0] pool_hash [POOL];
        logic [KEY_W-1:0]  fill_key [FILL];
        logic [HASH_W-1:0] fill_hash [FILL];
        logic [KEY_W-1:0]  ones;
        logic [KEY_W-1:0]  ka;
        logic [KEY_W-1:0]  kb;
        int unsigned base;
        int unsigned pick;
        int unsigned dice;
        int round;

        ones = '1;
        ka = 64'h0123_4567_89AB_CDEF;
        kb = 64'h8000_0000_0000_0001;

        queue_req(REQ_CLEAR, '0, '0, '0);
        queue_req(REQ_LOOKUP, '0, '0, '0);
        queue_req(REQ_INSERT, ones, '1, '1);
        queue_req(REQ_INSERT, '0, '0, '0);
        queue_req(REQ_INSERT, ka, 32'h0000_00FF, 32'h5A5A_5A5A);
        queue_req(REQ_LOOKUP, ka, 32'h0000_00FF, '0);
        queue_req(REQ_INSERT, ones, '1, 32'h1234_5678);
        queue_req(REQ_INSERT, kb, '1, 32'h0000_0001);
        queue_req(REQ_INSERT, ones, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(REQ_REMOVE, ones, '1, '0);
        queue_req(REQ_LOOKUP, kb, '1, '0);
        queue_req(REQ_REMOVE, ones, '1, '0);
        queue_req(REQ_INSERT, ones, '1, 32'h0000_0002);
        queue_req(REQ_LOOKUP, ones, '1, '0);
        queue_req(REQ_LOOKUP, ones, 32'h7FFF_FFFF, '0);
        queue_req(REQ_REMOVE, '0, '0, '1);
        queue_req(REQ_LOOKUP, '0, '0, '0);
        queue_req(REQ_LOOKUP, ka, 32'h0000_00FF, '1);
        queue_req(REQ_CLEAR, ones, '1, '1);
        queue_req(REQ_LOOKUP, ka, 32'h0000_00FF, '0);
        queue_req(REQ_REMOVE, kb, '1, '0);
        queue_req(REQ_INSERT, ka, 32'h0000_00FF, 32'h0000_0003);

        round = 0;
        while (requests_waiting.size() < ITEMS)
        begin
            base = $urandom_range(0, SLOTS - 1);
            if (round % 3 == 0)
            begin
                // fill past the limit, then poke at the full table
                queue_req(REQ_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
                for (int i = 0; i < FILL; i++)
                begin
                    fill_key[i] = {$urandom, $urandom};
                    fill_hash[i] = (i % 2 == 0) ? near_slot(base, 48) : $urandom;
                    queue_req(REQ_INSERT, fill_key[i], fill_hash[i], $urandom);
                end
                for (int i = 0; i < 30; i++)
                begin
                    pick = $urandom_range(0, FILL - 1);
                    dice = $urandom_range(0, 3);
                    case (dice)
                        0: queue_req(REQ_INSERT, fill_key[pick], fill_hash[pick], $urandom);
                        1: queue_req(REQ_INSERT, {$urandom, $urandom}, $urandom, $urandom);
                        2: queue_req(REQ_LOOKUP, fill_key[pick], fill_hash[pick], $urandom);
                        default: queue_req(REQ_REMOVE, fill_key[pick], fill_hash[pick], $urandom);
                    endcase
                end
            end
            else
            begin
                for (int i = 0; i < POOL; i++)
                begin
                    pool_key[i] = {$urandom, $urandom};
                    pool_hash[i] = near_slot(base, 16);
                    dice = $urandom_range(0, 99);
                    if (i > 0 && dice < 10)
                        pool_key[i] = pool_key[i - 1];
                    else if (i > 0 && dice < 20)
                        pool_hash[i] = pool_hash[i - 1];
                end
                if ($urandom_range(0, 1) == 1)
                    queue_req(REQ_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
                for (int i = 0; i < 120; i++)
                begin
                    pick = $urandom_range(0, POOL - 1);
                    dice = $urandom_range(0, 99);
                    if (dice < 3)
                        queue_req(req_t'($urandom_range(0, 3)), {$urandom, $urandom},
                                  $urandom, $urandom);
                    else if (dice < 5)
                        queue_req(REQ_CLEAR, pool_key[pick], pool_hash[pick], $urandom);
                    else if (dice < 45)
                        queue_req(REQ_INSERT, pool_key[pick], pool_hash[pick], $urandom);
                    else if (dice < 75)
                        queue_req(REQ_LOOKUP, pool_key[pick], pool_hash[pick], $urandom);
                    else
                        queue_req(REQ_REMOVE, pool_key[pick], pool_hash[pick], $urandom);
                end
            end
            round++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_waiting.size() != 0 || in_valid)
            @(posedge clk);
        while (answers_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
